// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/mexp_pkg.sv =====
package mexp_pkg;

   localparam int FIELD_BITS        = 32;
   localparam int OPERAND_BITS_DEF  = 32;
   localparam int EXPONENT_BITS_DEF = 32;

   typedef logic [3:0] op_type;
   typedef logic [2:0] cond_type;
   typedef logic [3:0] step_type;

   // Datapath operations.
   localparam op_type OP_NONE       = 4'd0;
   localparam op_type OP_LOAD       = 4'd1;
   localparam op_type OP_DIV_START  = 4'd2;
   localparam op_type OP_DIV_STEP   = 4'd3;
   localparam op_type OP_MULR_START = 4'd4;
   localparam op_type OP_MULR_STEP  = 4'd5;
   localparam op_type OP_MULB_START = 4'd6;
   localparam op_type OP_MULB_STEP  = 4'd7;
   localparam op_type OP_NEXT_E     = 4'd8;
   localparam op_type OP_CLR_R      = 4'd9;
   localparam op_type OP_EMIT       = 4'd10;

   // Jump conditions.
   localparam cond_type C_NEVER    = 3'd0;
   localparam cond_type C_ALWAYS   = 3'd1;
   localparam cond_type C_NO_START = 3'd2;
   localparam cond_type C_MZERO    = 3'd3;
   localparam cond_type C_CNT_NZ   = 3'd4;
   localparam cond_type C_EBIT_CLR = 3'd5;
   localparam cond_type C_ECNT_NZ  = 3'd6;
   localparam cond_type C_OUT_FREE = 3'd7;

   // Program steps.
   localparam step_type STEP_IDLE      = 4'd0;
   localparam step_type STEP_CHECK     = 4'd1;
   localparam step_type STEP_DIV_INIT  = 4'd2;
   localparam step_type STEP_DIV       = 4'd3;
   localparam step_type STEP_TEST      = 4'd4;
   localparam step_type STEP_MULR_INIT = 4'd5;
   localparam step_type STEP_MULR      = 4'd6;
   localparam step_type STEP_MULB_INIT = 4'd7;
   localparam step_type STEP_MULB      = 4'd8;
   localparam step_type STEP_NEXT      = 4'd9;
   localparam step_type STEP_DONE      = 4'd10;
   localparam step_type STEP_HOLD      = 4'd11;
   localparam step_type STEP_ZERO      = 4'd12;
   localparam step_type STEP_LAST      = STEP_ZERO;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic m_zero;
      logic cnt_nz;
      logic ebit;
      logic ecnt_nz;
   } status_type;

   // The control store. A step jumps to its target when its condition holds,
   // and otherwise falls through to the next step.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      unique case (step)
         STEP_IDLE:      word = {OP_LOAD,       C_NO_START, STEP_IDLE};
         STEP_CHECK:     word = {OP_NONE,       C_MZERO,    STEP_ZERO};
         STEP_DIV_INIT:  word = {OP_DIV_START,  C_NEVER,    STEP_IDLE};
         STEP_DIV:       word = {OP_DIV_STEP,   C_CNT_NZ,   STEP_DIV};
         STEP_TEST:      word = {OP_NONE,       C_EBIT_CLR, STEP_MULB_INIT};
         STEP_MULR_INIT: word = {OP_MULR_START, C_NEVER,    STEP_IDLE};
         STEP_MULR:      word = {OP_MULR_STEP,  C_CNT_NZ,   STEP_MULR};
         STEP_MULB_INIT: word = {OP_MULB_START, C_NEVER,    STEP_IDLE};
         STEP_MULB:      word = {OP_MULB_STEP,  C_CNT_NZ,   STEP_MULB};
         STEP_NEXT:      word = {OP_NEXT_E,     C_ECNT_NZ,  STEP_TEST};
         STEP_DONE:      word = {OP_EMIT,       C_OUT_FREE, STEP_IDLE};
         STEP_HOLD:      word = {OP_NONE,       C_ALWAYS,   STEP_DONE};
         STEP_ZERO:      word = {OP_CLR_R,      C_ALWAYS,   STEP_DONE};
         default:        word = {OP_NONE,       C_ALWAYS,   STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

// ===== rtl/mexp_datapath.sv =====
`include "assert_macros.svh"

module mexp_datapath import mexp_pkg::*; #(
   parameter int OPERAND_BITS  = OPERAND_BITS_DEF,
   parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  op_type                  op,
   input  logic [FIELD_BITS-1:0]   base_value,
   input  logic [FIELD_BITS-1:0]   exponent_value,
   input  logic [FIELD_BITS-1:0]   modulus_value,
   output status_type              status,
   output logic [OPERAND_BITS-1:0] result
);

   localparam int CNT_W  = $clog2(OPERAND_BITS);
   localparam int ECNT_W = (EXPONENT_BITS > 1) ? $clog2(EXPONENT_BITS) : 1;
   localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(OPERAND_BITS - 1);
   localparam logic [ECNT_W-1:0] ECNT_MAX = ECNT_W'(EXPONENT_BITS - 1);

   logic [OPERAND_BITS-1:0]  b_ff, b_in;
   logic [OPERAND_BITS-1:0]  m_ff, m_in;
   logic [OPERAND_BITS-1:0]  r_ff, r_in;
   logic [OPERAND_BITS-1:0]  acc_ff, acc_in;
   logic [OPERAND_BITS-1:0]  y_ff, y_in;
   logic [EXPONENT_BITS-1:0] e_ff, e_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [ECNT_W-1:0]        ecnt_ff, ecnt_in;

   logic [OPERAND_BITS:0]    dbl_full, sum_full, div_full, m_wide;
   logic [OPERAND_BITS-1:0]  dbl_mod, sum_mod, mul_next, div_next;

   assign m_wide = {1'b0, m_ff};

   // One bit of the shift-and-add modular product: double, then add the base when the multiplier bit is set.
   always_comb begin
      dbl_full = {acc_ff, 1'b0};
      if (dbl_full >= m_wide) begin
         dbl_full = dbl_full - m_wide;
      end
      dbl_mod  = dbl_full[OPERAND_BITS-1:0];
      sum_full = {1'b0, dbl_mod} + {1'b0, b_ff};
      if (sum_full >= m_wide) begin
         sum_full = sum_full - m_wide;
      end
      sum_mod  = sum_full[OPERAND_BITS-1:0];
      mul_next = y_ff[OPERAND_BITS-1] ? sum_mod : dbl_mod;
   end

   // One bit of the restoring division that reduces the base.
   always_comb begin
      div_full = {acc_ff, b_ff[OPERAND_BITS-1]};
      if (div_full >= m_wide) begin
         div_full = div_full - m_wide;
      end
      div_next = div_full[OPERAND_BITS-1:0];
   end

   always_comb begin
      b_in    = b_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      acc_in  = acc_ff;
      y_in    = y_ff;
      e_in    = e_ff;
      cnt_in  = cnt_ff;
      ecnt_in = ecnt_ff;
      unique case (op)
         OP_LOAD: begin
            b_in    = OPERAND_BITS'(base_value);
            m_in    = OPERAND_BITS'(modulus_value);
            e_in    = EXPONENT_BITS'(exponent_value);
            r_in    = OPERAND_BITS'(1);
            ecnt_in = ECNT_MAX;
         end
         OP_DIV_START: begin
            acc_in = '0;
            cnt_in = CNT_MAX;
         end
         OP_DIV_STEP: begin
            acc_in = div_next;
            cnt_in = cnt_ff - CNT_W'(1);
            b_in   = (cnt_ff == '0) ? div_next : {b_ff[OPERAND_BITS-2:0], 1'b0};
         end
         OP_MULR_START: begin
            acc_in = '0;
            // The running result is only out of range when it is the initial
            // one and the modulus is one; it then reduces to zero.
            y_in   = (r_ff >= m_ff) ? '0 : r_ff;
            cnt_in = CNT_MAX;
         end
         OP_MULB_START: begin
            acc_in = '0;
            y_in   = b_ff;
            cnt_in = CNT_MAX;
         end
         OP_MULR_STEP: begin
            acc_in = mul_next;
            y_in   = {y_ff[OPERAND_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               r_in = mul_next;
            end
         end
         OP_MULB_STEP: begin
            acc_in = mul_next;
            y_in   = {y_ff[OPERAND_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               b_in = mul_next;
            end
         end
         OP_NEXT_E: begin
            e_in    = e_ff >> 1;
            ecnt_in = ecnt_ff - ECNT_W'(1);
         end
         OP_CLR_R: begin
            r_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      b_ff    <= b_in;
      m_ff    <= m_in;
      r_ff    <= r_in;
      acc_ff  <= acc_in;
      y_ff    <= y_in;
      e_ff    <= e_in;
      cnt_ff  <= cnt_in;
      ecnt_ff <= ecnt_in;
   end

   assign status.m_zero  = (m_ff == '0);
   assign status.cnt_nz  = (cnt_ff != '0);
   assign status.ebit    = e_ff[0];
   assign status.ecnt_nz = (ecnt_ff != '0);
   assign result         = r_ff;

   `ASSERT_IMPL(a_mul_acc_reduced, clock, reset, (op == OP_MULR_STEP || op == OP_MULB_STEP), acc_ff < m_ff)
   `ASSERT_IMPL(a_div_acc_reduced, clock, reset, op == OP_DIV_STEP, acc_ff < m_ff)
   `ASSERT_NEXT(a_mul_start_init, clock, reset, (op == OP_MULR_START || op == OP_MULB_START), cnt_ff == CNT_MAX && acc_ff == '0)

endmodule

// ===== rtl/modular_exponentiation_top.sv =====
// After a word is accepted, a check step and a restoring division reduce the base; then, for
// each exponent bit, the result is multiplied by the base when the bit is set, and the base is
// squared. A zero modulus answers zero. One word is in work at a time; a new word can be taken
// in the cycle after the result has moved to the output register. The rate is set by the
// bit-serial modular multiply, one operand bit per cycle.
// Reset is synchronous and active high; it returns the sequencer to idle and empties the output.
`include "assert_macros.svh"

module modular_exponentiation_top import mexp_pkg::*; #(
   parameter int OPERAND_BITS  = OPERAND_BITS_DEF,
   parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FIELD_BITS-1:0] req_base_value,
   input  logic [FIELD_BITS-1:0] req_exponent_value,
   input  logic [FIELD_BITS-1:0] req_modulus_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [FIELD_BITS-1:0] rsp_power_result
);

   step_type                pc_ff, pc_in;
   ucode_type               uword;
   status_type              status;
   logic [OPERAND_BITS-1:0] result;
   logic                    cond_true;
   logic                    out_free;
   logic                    emit;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0]   rsp_data_ff, rsp_data_in;

   assign uword     = ucode_rom(pc_ff);
   assign req_stall = (pc_ff != STEP_IDLE);
   assign out_free  = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      unique case (uword.cond)
         C_NEVER:    cond_true = 1'b0;
         C_ALWAYS:   cond_true = 1'b1;
         C_NO_START: cond_true = !req_valid;
         C_MZERO:    cond_true = status.m_zero;
         C_CNT_NZ:   cond_true = status.cnt_nz;
         C_EBIT_CLR: cond_true = !status.ebit;
         C_ECNT_NZ:  cond_true = status.ecnt_nz;
         C_OUT_FREE: cond_true = out_free;
         default:    cond_true = 1'b0;
      endcase
   end

   assign pc_in = cond_true ? uword.target : pc_ff + step_type'(1);
   assign emit  = (uword.op == OP_EMIT) && out_free;

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = emit ? FIELD_BITS'(result) : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   mexp_datapath #(
      .OPERAND_BITS  (OPERAND_BITS),
      .EXPONENT_BITS (EXPONENT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .op             (uword.op),
      .base_value     (req_base_value),
      .exponent_value (req_exponent_value),
      .modulus_value  (req_modulus_value),
      .status         (status),
      .result         (result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

   `ASSERT_NEXT(a_emit_sets_valid, clock, reset, emit, rsp_valid_ff)
   `ASSERT_IMPL(a_pc_in_program, clock, reset, 1'b1, pc_ff <= STEP_LAST)
   `ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && !req_stall, pc_ff == STEP_CHECK)

endmodule

// ===== test/tb_modular_exponentiation_top.sv =====
`timescale 1ns / 1ps

module tb_modular_exponentiation_top;
   import mexp_pkg::*;

   localparam int RANDOM_WORDS    = 270;
   localparam int HOLD_OFF_AFTER  = 40;
   localparam int HOLD_OFF_CYCLES = 6000;
   localparam int DRAIN_CYCLES    = 2300;
   localparam int WATCHDOG_CYCLES = 3_000_000;

   class power_checker;
      logic [FIELD_BITS-1:0] expected_powers[$];
      int mismatch_count = 0;

      function logic [FIELD_BITS-1:0] predict_power(logic [FIELD_BITS-1:0] base,
                                                     logic [FIELD_BITS-1:0] exponent,
                                                     logic [FIELD_BITS-1:0] modulus);
         logic [63:0] square;
         logic [63:0] running;
         logic [63:0] divisor;
         if (modulus == '0) begin
            return '0;
         end
         divisor = 64'(modulus);
         square  = 64'(base) % divisor;
         running = 64'd1;
         for (int i = 0; i < FIELD_BITS; i++) begin
            if (exponent[i]) begin
               running = (running * square) % divisor;
            end
            square = (square * square) % divisor;
         end
         return running[FIELD_BITS-1:0];
      endfunction

      function void note_operands(logic [FIELD_BITS-1:0] base,
                                  logic [FIELD_BITS-1:0] exponent,
                                  logic [FIELD_BITS-1:0] modulus);
         expected_powers.push_back(predict_power(base, exponent, modulus));
      endfunction

      function void check_power(logic [FIELD_BITS-1:0] actual);
         logic [FIELD_BITS-1:0] wanted;
         if (expected_powers.size() == 0) begin
            $error("power_result: no word expected, actual %h", actual);
            mismatch_count++;
            return;
         end
         wanted = expected_powers.pop_front();
         if (actual !== wanted) begin
            $error("power_result: expected %h, actual %h", wanted, actual);
            mismatch_count++;
         end
      endfunction

      function int pending();
         return expected_powers.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [FIELD_BITS-1:0] req_base_value = '0;
   logic [FIELD_BITS-1:0] req_exponent_value = '0;
   logic [FIELD_BITS-1:0] req_modulus_value = '1;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b1;
   logic [FIELD_BITS-1:0] rsp_power_result;

   power_checker power_book = new;
   bit           send_steady = 1'b0;

   modular_exponentiation_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_base_value     (req_base_value),
      .req_exponent_value (req_exponent_value),
      .req_modulus_value  (req_modulus_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_power_result   (rsp_power_result)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int idle_cycles(inout bit steady);
      if ($urandom_range(0, 19) == 0) begin
         steady = !steady;
      end
      return steady ? 0 : int'($urandom_range(0, 4));
   endfunction

   task automatic send_word(input logic [FIELD_BITS-1:0] base,
                            input logic [FIELD_BITS-1:0] exponent,
                            input logic [FIELD_BITS-1:0] modulus);
      int gap;
      gap = idle_cycles(send_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_base_value     <= base;
      req_exponent_value <= exponent;
      req_modulus_value  <= modulus;
      do @(posedge clock); while (req_stall);
      power_book.note_operands(base, exponent, modulus);
   endtask

   task automatic send_random_word();
      logic [FIELD_BITS-1:0] base;
      logic [FIELD_BITS-1:0] exponent;
      logic [FIELD_BITS-1:0] modulus;
      case ($urandom_range(0, 3))
         0: modulus = $urandom_range(1, 16);
         1: modulus = $urandom() | 32'h8000_0000;
         2: modulus = 32'hFFFF_FFFF - $urandom_range(0, 64);
         default: modulus = $urandom();
      endcase
      if (modulus == '0) begin
         modulus = 32'd1;
      end
      case ($urandom_range(0, 4))
         0: base = '0;
         1: base = modulus - 32'd1;
         2: base = $urandom_range(0, 3);
         default: base = $urandom();
      endcase
      case ($urandom_range(0, 5))
         0: exponent = '0;
         1: exponent = '1;
         2: exponent = $urandom_range(0, 15);
         default: exponent = $urandom();
      endcase
      send_word(base, exponent, modulus);
   endtask

   initial begin : result_sink
      int gap;
      int taken;
      bit steady;
      taken  = 0;
      steady = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_OFF_AFTER) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         gap = idle_cycles(steady);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         power_book.check_power(rsp_power_result);
         taken++;
      end
   end

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
      send_word(32'h0000_0005, 32'h0000_0000, 32'h0000_0001);
      send_word(32'h0000_0005, 32'h0000_0003, 32'h0000_0001);
      send_word(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(32'h0000_0000, 32'h0000_0001, 32'h0000_0007);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
      send_word(32'h0000_0002, 32'h0000_000A, 32'h0000_03E8);
      send_word(32'h0000_0003, 32'h8000_0000, 32'h000F_4243);
      send_word(32'h1234_5678, 32'h0000_0001, 32'h0000_0064);
      send_word(32'h0000_0007, 32'h0000_0002, 32'h0000_0000);
      send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(32'h0000_0002, 32'h0000_001F, 32'h8000_0000);
      send_word(32'h0000_0002, 32'h0000_001F, 32'h8000_0001);
      send_word(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002);
      send_word(32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0002);
      send_word(32'hABCD_EF01, 32'h5555_5555, 32'hAAAA_AAAA);
      send_word(32'h8000_0000, 32'hAAAA_AAAA, 32'hFFFF_FFFE);

      repeat (RANDOM_WORDS) send_random_word();
      req_valid <= 1'b0;

      while (power_book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (power_book.mismatch_count == 0 && power_book.pending() == 0) begin
         $display("PASS modular_exponentiation_top");
      end else begin
         $display("FAIL modular_exponentiation_top");
      end
      $finish;
   end

   initial begin : watchdog
      #(WATCHDOG_CYCLES * 10);
      $display("FAIL modular_exponentiation_top");
      $finish;
   end

endmodule

// ===== modular_exponentiation_top.f =====
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_datapath.sv
rtl/modular_exponentiation_top.sv
test/tb_modular_exponentiation_top.sv
